@@ rtl/core/rpa_pkg.sv @@
// ----------------------------------------------------------------------------
// rpa_pkg - shared definitions for the packet airtime calculator
// Field widths, register indexes, saturation limits and the divider structs.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int LEN_W      = 8;   // payload length in bytes
    localparam int AIR_W      = 20;  // airtime in ms
    localparam int INT_W      = 22;  // interval in ms
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;  // widest register is the bandwidth
    localparam int DVD_W      = 33;  // 2N + B
    localparam int DIV_W      = 20;  // 2B

    localparam logic [AIR_W-1:0] AIRTIME_MAX  = '1;
    localparam logic [INT_W-1:0] INTERVAL_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SF  = 3'd0,
        CFG_BW  = 3'd1,
        CFG_CR  = 3'd2,
        CFG_PRE = 3'd3,
        CFG_PAD = 3'd4,
        CFG_GAP = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic             vld;
        logic [DVD_W-1:0] dvd;
    } t_div_req;

    typedef struct packed {
        logic             vld;
        logic             sat;
        logic [AIR_W-1:0] quo;
    } t_div_res;

endpackage

@@ rtl/core/rpa_if.sv @@
// ----------------------------------------------------------------------------
// rpa_if - handshake channels of the packet airtime calculator
// Input item channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface rpa_in_if import rpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] payload_length;

    modport source (output valid, output payload_length, input ready);
    modport sink   (input valid, input payload_length, output ready);
endinterface

interface rpa_out_if import rpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AIR_W-1:0] airtime_ms;
    logic [INT_W-1:0] interval_ms;

    modport source (output valid, output airtime_ms, output interval_ms, input ready);
    modport sink   (input valid, input airtime_ms, input interval_ms, output ready);
endinterface

interface rpa_cfg_if import rpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/rpa_div.sv @@
// ----------------------------------------------------------------------------
// rpa_div - pipelined restoring divider for the airtime quotient
// One quotient bit per stage after an overflow check; flags quotients that
// do not fit the airtime field (zero divisor included).
// ----------------------------------------------------------------------------
module rpa_div import rpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [DIV_W-1:0] i_divisor,
    input  t_div_req         i_req,
    output t_div_res         o_res
);

    localparam int STEPS = AIR_W;
    localparam int TOP_W = DVD_W - STEPS;

    logic             r_vld [STEPS+1];
    logic             r_sat [STEPS+1];
    logic [DIV_W-1:0] r_rem [STEPS+1];
    logic [STEPS-1:0] r_low [STEPS+1];
    logic [STEPS-1:0] r_quo [STEPS+1];

    logic [DIV_W+STEPS-1:0] w_limit;
    logic                   w_sat;

    // quotient overflows exactly when the dividend reaches divisor * 2^STEPS
    assign w_limit = {i_divisor, {STEPS{1'b0}}};
    assign w_sat   = {{(DIV_W+STEPS-DVD_W){1'b0}}, i_req.dvd} >= w_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_req.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= w_sat;
            r_rem[0] <= {{(DIV_W-TOP_W){1'b0}}, i_req.dvd[DVD_W-1:STEPS]};
            r_low[0] <= i_req.dvd[STEPS-1:0];
            r_quo[0] <= '0;
        end
    end

    for (genvar j = 1; j <= STEPS; j++) begin : g_step
        logic [DIV_W:0] w_trial;
        logic           w_ge;
        logic [DIV_W:0] w_diff;

        assign w_trial = {r_rem[j-1], r_low[j-1][STEPS-j]};
        assign w_ge    = w_trial >= {1'b0, i_divisor};
        assign w_diff  = w_trial - {1'b0, i_divisor};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[j] <= r_sat[j-1];
                r_low[j] <= r_low[j-1];
                r_rem[j] <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_quo[j] <= {r_quo[j-1][STEPS-2:0], w_ge};
            end
        end
    end

    assign o_res.vld = r_vld[STEPS];
    assign o_res.sat = r_sat[STEPS];
    assign o_res.quo = r_quo[STEPS];

endmodule

@@ rtl/core/radio_packet_airtime.sv @@
// ----------------------------------------------------------------------------
// radio_packet_airtime - packet time on air and least send interval
// Throughput: one payload length per cycle while no result is parked in the
// skid stage; 32 register stages, the 21-stage restoring divider for the
// millisecond quotient (overflow check plus one stage per quotient bit) and
// 11 others, the output register among them.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module radio_packet_airtime import rpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rpa_cfg_if.sink   i_cfg,
    rpa_in_if.sink    i_pkt,
    rpa_out_if.source o_res
);

    localparam logic [3:0]  SF_MIN      = 4'd6;
    localparam logic [3:0]  SF_MAX      = 4'd12;
    localparam logic [3:0]  SF_LDRO     = 4'd11;
    localparam logic [3:0]  CR_MIN      = 4'd5;
    localparam logic [3:0]  CR_MAX      = 4'd8;
    localparam logic [18:0] BW_LDRO     = 19'd125000;
    // 4.25 extra preamble symbols and 8 base payload symbols, both times four
    localparam logic [11:0] FIXED_SYM4  = 12'd49;
    localparam logic [9:0]  HDR_OFS     = 10'd11;
    // 2 * 1000 ms / 4 quarter symbols
    localparam logic [32:0] MS_SCALE2   = 33'd500;
    localparam int          RCP_ONE     = 65536;
    localparam int          PCT_SHIFT   = 35;
    localparam logic [28:0] PCT_RECIP   =
        29'(((64'd1 << PCT_SHIFT) + 64'd99) / 64'd100);

    localparam logic [3:0]  SF_RESET    = 4'd7;
    localparam logic [18:0] BW_RESET    = 19'd125000;
    localparam logic [3:0]  CR_RESET    = 4'd5;
    localparam logic [7:0]  PRE_RESET   = 8'd8;

    function automatic logic [13:0] f_recip(input logic [3:0] k);
        logic [13:0] v;
        v = '0;
        unique case (k)
            4'd6:    v = 14'(RCP_ONE / 6);
            4'd7:    v = 14'(RCP_ONE / 7);
            4'd8:    v = 14'(RCP_ONE / 8);
            4'd9:    v = 14'(RCP_ONE / 9);
            4'd10:   v = 14'(RCP_ONE / 10);
            4'd11:   v = 14'(RCP_ONE / 11);
            default: v = 14'(RCP_ONE / 12);
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]  r_sf;
    logic [18:0] r_bw;
    logic [3:0]  r_cr;
    logic [7:0]  r_pre;
    logic [7:0]  r_pad;
    logic [15:0] r_gap;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf  <= SF_RESET;
            r_bw  <= BW_RESET;
            r_cr  <= CR_RESET;
            r_pre <= PRE_RESET;
            r_pad <= '0;
            r_gap <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SF:  r_sf  <= i_cfg.data[3:0];
                CFG_BW:  r_bw  <= i_cfg.data[18:0];
                CFG_CR:  r_cr  <= i_cfg.data[3:0];
                CFG_PRE: r_pre <= i_cfg.data[7:0];
                CFG_PAD: r_pad <= i_cfg.data[7:0];
                CFG_GAP: r_gap <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // settings must only change while idle (the block does not enforce this), so these are constant per item
    logic [3:0]       w_sf;
    logic [3:0]       w_cr;
    logic             w_de;
    logic [3:0]       w_k;
    logic [DIV_W-1:0] w_div;

    always_comb begin
        priority if (r_sf < SF_MIN) w_sf = SF_MIN;
        else if (r_sf > SF_MAX)     w_sf = SF_MAX;
        else                        w_sf = r_sf;
        priority if (r_cr < CR_MIN) w_cr = CR_MIN;
        else if (r_cr > CR_MAX)     w_cr = CR_MAX;
        else                        w_cr = r_cr;
    end

    assign w_de  = (w_sf >= SF_LDRO) && (r_bw <= BW_LDRO);
    assign w_k   = w_sf - {2'b00, w_de, 1'b0};
    assign w_div = {r_bw, 1'b0};

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic r_skid_vld;
    logic w_en;

    assign w_en        = !r_skid_vld;
    assign i_pkt.ready = w_en;

    // ------------------------------------------------------------------
    // Symbol count: ceil(m / k) with m = 2L + 11 - SF
    // ------------------------------------------------------------------
    logic [9:0]  w_t;
    logic [9:0]  w_x;
    logic [23:0] w_prod;
    logic [10:0] w_qk;
    logic [10:0] w_sc;
    logic [32:0] w_dvd;

    logic        r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    logic [9:0]  r1_x;
    logic [22:0] r2_prod;
    logic [9:0]  r2_x;
    logic [6:0]  r3_q;
    logic [9:0]  r3_rem;
    logic [6:0]  r4_span;
    logic [11:0] r5_tot;
    logic [23:0] r6_sh;
    logic [32:0] r7_dvd;

    assign w_t    = {1'b0, i_pkt.payload_length, 1'b0} + HDR_OFS;
    assign w_x    = (w_t > {6'b0, w_sf})
                  ? (w_t + {6'b0, w_k} - 10'd1 - {6'b0, w_sf}) : '0;
    assign w_prod = r1_x * f_recip(w_k);
    assign w_qk   = r2_prod[22:16] * w_k;
    assign w_sc   = r4_span * w_cr;
    assign w_dvd  = {9'b0, r6_sh} * MS_SCALE2 + {14'b0, r_bw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_pkt.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x    <= w_x;
            r2_prod <= w_prod[22:0];
            r2_x    <= r1_x;
            // estimate is exact or one short
            r3_q    <= r2_prod[22:16];
            r3_rem  <= r2_x - w_qk[9:0];
            r4_span <= r3_q + {6'b0, (r3_rem >= {6'b0, w_k})};
            r5_tot  <= {w_sc[9:0], 2'b00} + {2'b00, r_pre, 2'b00} + FIXED_SYM4;
            r6_sh   <= {12'b0, r5_tot} << w_sf;
            r7_dvd  <= w_dvd;
        end
    end

    // ------------------------------------------------------------------
    // Millisecond quotient: (2N + B) / 2B
    // ------------------------------------------------------------------
    t_div_req w_req;
    t_div_res w_res;

    assign w_req.vld = r7_vld;
    assign w_req.dvd = r7_dvd;

    rpa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_divisor (w_div),
        .i_req     (w_req),
        .o_res     (w_res)
    );

    // ------------------------------------------------------------------
    // Dead air and interval
    // ------------------------------------------------------------------
    logic [AIR_W-1:0] w_air;
    logic [56:0]      w_pm;
    logic [INT_W-1:0] w_dead;
    logic [INT_W:0]   w_sum;

    logic             ra_vld, rb_vld, rc_vld;
    logic [AIR_W-1:0] ra_air, rb_air, rc_air;
    logic [27:0]      ra_p;
    logic [INT_W-1:0] rb_prop;
    logic [INT_W-1:0] rc_int;

    assign w_air  = w_res.sat ? AIRTIME_MAX : w_res.quo;
    assign w_pm   = ra_p * PCT_RECIP;
    assign w_dead = (rb_prop > {6'b0, r_gap}) ? rb_prop : {6'b0, r_gap};
    assign w_sum  = {3'b0, rb_air} + {1'b0, w_dead};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
            rb_vld <= 1'b0;
            rc_vld <= 1'b0;
        end else if (w_en) begin
            ra_vld <= w_res.vld;
            rb_vld <= ra_vld;
            rc_vld <= rb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            ra_air  <= w_air;
            ra_p    <= w_air * r_pad;
            rb_air  <= ra_air;
            // exact floor divide by 100 for products below 2^30
            rb_prop <= w_pm[56:PCT_SHIFT];
            rc_air  <= rb_air;
            rc_int  <= (w_sum > {1'b0, INTERVAL_MAX}) ? INTERVAL_MAX : w_sum[INT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic             r_out_vld;
    logic [AIR_W-1:0] r_out_air, r_skid_air;
    logic [INT_W-1:0] r_out_int, r_skid_int;
    logic             w_exit;
    logic             w_out_free;

    assign w_exit     = rc_vld && w_en;
    assign w_out_free = !r_out_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_vld  <= r_skid_vld || w_exit;
                r_skid_vld <= 1'b0;
            end else if (w_exit) begin
                // result waits: park the leaving item
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_vld) begin
                r_out_air <= r_skid_air;
                r_out_int <= r_skid_int;
            end else begin
                r_out_air <= rc_air;
                r_out_int <= rc_int;
            end
        end else if (w_exit) begin
            r_skid_air <= rc_air;
            r_skid_int <= rc_int;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.airtime_ms  = r_out_air;
    assign o_res.interval_ms = r_out_int;

endmodule

@@ rtl/core/rpa_chk.sv @@
// ----------------------------------------------------------------------------
// rpa_chk - port-level checks for the packet airtime calculator
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rpa_chk import rpa_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [AIR_W-1:0] i_out_air,
    input logic [INT_W-1:0] i_out_int
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_air) && $stable(i_out_int))
        else $error("result changed while stalled");

    // dead air is never negative
    a_int_ge_air: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_int >= {2'b00, i_out_air})
        else $error("interval below airtime");

    // ready right after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("not ready after reset");

    // input only stalls behind a result that was held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("input stalled without a held result");

endmodule

bind radio_packet_airtime rpa_chk u_rpa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pkt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_air   (o_res.airtime_ms),
    .i_out_int   (o_res.interval_ms)
);

@@ tb/radio_packet_airtime_tb.sv @@
// ----------------------------------------------------------------------------
// radio_packet_airtime_tb - self-checking bench for the airtime calculator
// Drives payload lengths under a series of register settings. These include
// the clamped spreading factors and coding rates, zero and tiny bandwidths,
// the optimisation boundary and writes to unused indexes. Random idling is
// applied on both channels. Every result is compared against an exact
// integer model of the time on air and the send interval.
// ----------------------------------------------------------------------------
module radio_packet_airtime_tb import rpa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 40;    // extra drain after the last phase
    localparam int RANDOM_PHASES = 20;
    localparam int PHASE_ITEMS   = 82;
    localparam int QUIET_PHASES  = 3;
    localparam int REPORT_CAP    = 100;

    // indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam logic [LEN_W-1:0] BOUNDARY_LENGTHS [8] = '{
        8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255, 8'h55, 8'hAA
    };

    typedef struct packed {
        logic [AIR_W-1:0] airtime_ms;
        logic [INT_W-1:0] interval_ms;
    } t_airtime;

    class airtime_ledger;
        logic [3:0]  sf_reg;
        logic [18:0] bw_reg;
        logic [3:0]  cr_reg;
        logic [7:0]  pre_reg;
        logic [7:0]  pad_reg;
        logic [15:0] gap_reg;
        t_airtime    expected_airtimes[$];
        int          errors;
        int          accepted;
        int          compared;
        int          clipped;

        function new();
            sf_reg  = 4'd7;
            bw_reg  = 19'd125000;
            cr_reg  = 4'd5;
            pre_reg = 8'd8;
            pad_reg = 8'd0;
            gap_reg = 16'd0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SF:  sf_reg  = data[3:0];
                CFG_BW:  bw_reg  = data[18:0];
                CFG_CR:  cr_reg  = data[3:0];
                CFG_PRE: pre_reg = data[7:0];
                CFG_PAD: pad_reg = data[7:0];
                CFG_GAP: gap_reg = data[15:0];
                default: ;
            endcase
        endfunction

        function t_airtime airtime_of(logic [LEN_W-1:0] len);
            int unsigned sf, cr, de, den, span, syms;
            int          num;
            logic [63:0] chips, air, prop, dead, ivl;
            t_airtime    r;
            sf = 32'(sf_reg);
            if (sf < 6) sf = 6;
            if (sf > 12) sf = 12;
            cr = 32'(cr_reg);
            if (cr < 5) cr = 5;
            if (cr > 8) cr = 8;
            de = (sf >= 11 && bw_reg <= 19'd125000) ? 1 : 0;
            num = 8 * int'(len) - 4 * int'(sf) + 44;
            den = 4 * (sf - 2 * de);
            span = (num > 0) ? (num + den - 1) / den : 0;
            syms = 8 + span * cr;
            if (bw_reg == 0) begin
                air = 64'(AIRTIME_MAX);
            end else begin
                chips = (64'(4 * pre_reg + 17 + 4 * syms) << sf) * 250;
                air = (2 * chips + bw_reg) / (2 * 64'(bw_reg));
                if (air > AIRTIME_MAX) air = 64'(AIRTIME_MAX);
            end
            prop = air * pad_reg / 100;
            dead = (prop > gap_reg) ? prop : 64'(gap_reg);
            ivl = air + dead;
            if (ivl > INTERVAL_MAX) ivl = 64'(INTERVAL_MAX);
            r.airtime_ms  = air[AIR_W-1:0];
            r.interval_ms = ivl[INT_W-1:0];
            return r;
        endfunction

        function void note_length(logic [LEN_W-1:0] len);
            t_airtime r;
            r = airtime_of(len);
            if (r.airtime_ms == AIRTIME_MAX) clipped++;
            expected_airtimes.push_back(r);
            accepted++;
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s", $time, msg);
            else if (errors == REPORT_CAP + 1)
                $display("%0t: further mismatches counted but not shown", $time);
        endfunction

        function void check_result(logic [AIR_W-1:0] air, logic [INT_W-1:0] ivl);
            t_airtime want;
            if (expected_airtimes.size() == 0) begin
                complain($sformatf("result with none pending: expected nothing, got %0d / %0d",
                                   air, ivl));
                return;
            end
            want = expected_airtimes.pop_front();
            compared++;
            if (air !== want.airtime_ms)
                complain($sformatf("airtime_ms expected %0d, got %0d", want.airtime_ms, air));
            if (ivl !== want.interval_ms)
                complain($sformatf("interval_ms expected %0d, got %0d", want.interval_ms, ivl));
        endfunction

        function int pending();
            return expected_airtimes.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   hold_off = 0;
    int   settings = 0;

    airtime_ledger book = new();

    rpa_cfg_if cfg_bus ();
    rpa_in_if  pkt_bus ();
    rpa_out_if res_bus ();

    radio_packet_airtime dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pkt   (pkt_bus),
        .o_res   (res_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin
        wait (cycles == CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: hold ready low in random bursts
    initial begin
        res_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                res_bus.ready <= 1'b0;
                hold_off--;
            end else begin
                res_bus.ready <= 1'b1;
                if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct)
                    hold_off = $urandom_range(9, 1);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            book.check_result(res_bus.airtime_ms, res_bus.interval_ms);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        book.write_reg(idx, data);
    endtask

    // unused upper data bits carry noise, the block must mask them
    task automatic program_regs(input logic [3:0] sf, input logic [18:0] bw,
                                input logic [3:0] cr, input logic [7:0] pre,
                                input logic [7:0] pad, input logic [15:0] gap);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_SF,  {junk[18:4], sf});
        write_reg(CFG_BW,  bw);
        write_reg(CFG_CR,  {junk[14:0], cr});
        write_reg(CFG_PRE, {junk[10:0], pre});
        write_reg(CFG_PAD, {junk[18:8], pad});
        write_reg(CFG_GAP, {junk[2:0], gap});
        cfg_bus.valid <= 1'b0;
        settings++;
    endtask

    task automatic offer_length(input logic [LEN_W-1:0] len);
        pkt_bus.valid          <= 1'b1;
        pkt_bus.payload_length <= len;
        @(posedge i_clk);
        while (!pkt_bus.ready) @(posedge i_clk);
        book.note_length(len);
        if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
            pkt_bus.valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge i_clk);
        end
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        pkt_bus.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    function automatic int idle_level();
        case ($urandom_range(2, 0))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    task automatic random_phase(input int n);
        logic [3:0]  sf, cr;
        logic [18:0] bw;
        logic [7:0]  pre, pad;
        logic [15:0] gap;
        sf = ($urandom_range(4, 0) == 0) ? 4'($urandom) : 4'($urandom_range(12, 6));
        case ($urandom_range(9, 0))
            0:       bw = 19'($urandom);
            1:       bw = 19'($urandom_range(200, 0));
            2:       bw = 19'd125000;
            3:       bw = 19'd125001;
            default: bw = 19'($urandom_range(500000, 7800));
        endcase
        cr  = 4'($urandom);
        pre = $urandom_range(1, 0) ? 8'($urandom) : 8'($urandom_range(16, 6));
        pad = ($urandom_range(3, 0) == 0) ? 8'd0 : 8'($urandom);
        gap = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(500, 0));
        program_regs(sf, bw, cr, pre, pad, gap);
        repeat (n) begin
            if ($urandom_range(15, 0) == 0)
                offer_length($urandom_range(1, 0) ? 8'hFF : 8'h00);
            else
                offer_length(8'($urandom_range(255, 0)));
        end
        settle();
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        pkt_bus.valid          <= 1'b0;
        pkt_bus.payload_length <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.index          <= '0;
        cfg_bus.data           <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct   = 15;
        stall_pct = 15;
        foreach (BOUNDARY_LENGTHS[k]) offer_length(BOUNDARY_LENGTHS[k]);
        settle();

        // top spreading factor with optimisation on; empty payload gives no span
        program_regs(4'd12, 19'd125000, 4'd8, 8'd255, 8'd255, 16'hFFFF);
        offer_length(8'd0);
        offer_length(8'd255);
        offer_length(8'd1);
        settle();

        // just above the optimisation bandwidth; zero coding rate acts as 4/5
        program_regs(4'd11, 19'd125001, 4'd0, 8'd0, 8'd100, 16'd0);
        offer_length(8'd0);
        offer_length(8'd255);
        offer_length(8'd200);
        settle();

        // spreading factor below range, widest bandwidth field, gap dominates
        program_regs(4'd0, 19'h7FFFF, 4'd4, 8'd255, 8'd0, 16'hFFFF);
        offer_length(8'd0);
        offer_length(8'd255);
        settle();

        // spreading factor and coding rate above range, zero bandwidth
        program_regs(4'd15, 19'd0, 4'd15, 8'd200, 8'd255, 16'd1);
        offer_length(8'd3);
        offer_length(8'd77);
        settle();

        // airtime beyond the output range
        program_regs(4'd12, 19'd1, 4'd8, 8'd255, 8'd255, 16'd0);
        offer_length(8'd40);
        offer_length(8'd255);
        settle();

        // writes to unused indexes must leave the setting alone
        write_reg(IDX_SPARE_LO, 19'h7FFFF);
        write_reg(IDX_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_bus.valid <= 1'b0;
        offer_length(8'd40);
        offer_length(8'd255);
        settle();

        program_regs(4'd6, 19'd7800, 4'd8, 8'd0, 8'd1, 16'd1);
        offer_length(8'd0);
        offer_length(8'd255);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph >= RANDOM_PHASES - QUIET_PHASES) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = idle_level();
                stall_pct = idle_level();
            end
            random_phase(PHASE_ITEMS);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d payload lengths over %0d register settings, clamped codes,",
                 book.accepted, settings);
        $display("zero bandwidth and unused indexes included; %0d results compared, %0d clipped.",
                 book.compared, book.clipped);
        if (book.errors == 0 && book.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rpa_pkg.sv
rtl/core/rpa_if.sv
rtl/core/rpa_div.sv
rtl/core/radio_packet_airtime.sv
rtl/core/rpa_chk.sv
tb/radio_packet_airtime_tb.sv
